// ===== sv/slh_pkg.sv =====
// ----------------------------------------------------------------------------
// slh_pkg: shared types, constants and mixing functions
// Word rounds, tail rounds and finalization steps of the string hash.
// ----------------------------------------------------------------------------
package slh_pkg;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0] count_t;

  function automatic hash_t sext8(input logic [7:0] b);
    sext8 = {{(HASH_W-8){b[7]}}, b};
  endfunction

  // four valid bytes; the temporary is cut to 32 bits
  function automatic hash_t full_round(input hash_t h, input word_t w);
    hash_t       h1;
    hash_t       h2;
    logic [31:0] t;
    h1 = h + {48'd0, w[15:0]};
    t  = {5'd0, w[31:16], 11'd0} ^ h1[31:0];
    h2 = {h1[47:0], 16'd0} ^ {32'd0, t};
    full_round = h2 + (h2 >> 11);
  endfunction

  function automatic hash_t tail_round(input hash_t h, input word_t w,
                                       input logic [1:0] n);
    hash_t r;
    r = h;
    case (n)
      2'd3: begin
        r = r + {48'd0, w[15:0]};
        r = r ^ (r << 16);
        r = r ^ (sext8(w[23:16]) << 18);
        r = r + (r >> 11);
      end
      2'd2: begin
        r = r + {48'd0, w[15:0]};
        r = r ^ (r << 11);
        r = r + (r >> 17);
      end
      2'd1: begin
        r = r + sext8(w[7:0]);
        r = r ^ (r << 10);
        r = r + (r >> 1);
      end
      default: begin
        r = h;
      end
    endcase
    tail_round = r;
  endfunction

  // avalanche, split into three steps of one add each
  function automatic hash_t fin_step1(input hash_t h);
    hash_t r;
    r = h ^ (h << 3);
    fin_step1 = r + (r >> 5);
  endfunction

  function automatic hash_t fin_step2(input hash_t h);
    hash_t r;
    r = h ^ (h << 4);
    fin_step2 = r + (r >> 17);
  endfunction

  function automatic hash_t fin_step3(input hash_t h);
    hash_t r;
    r = h ^ (h << 25);
    fin_step3 = r + (r >> 6);
  endfunction

endpackage

// ===== sv/slh_fifo.sv =====
// ----------------------------------------------------------------------------
// slh_fifo: small hash queue
// First-in first-out store of 64-bit values with full and empty flags.
// ----------------------------------------------------------------------------
module slh_fifo #(
  parameter int unsigned DEPTH = slh_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slh_pkg::hash_t wr_data,
  output logic           full,
  input  logic           pop,
  output slh_pkg::hash_t rd_data,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  slh_pkg::hash_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/slh_front.sv =====
// ----------------------------------------------------------------------------
// slh_front: word intake and accumulator
// Runs one full or tail round per accepted word and hands the pre-final
// accumulator of each finished string to the finalization queue.
// ----------------------------------------------------------------------------
module slh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  slh_pkg::hash_t    seed,
  input  logic              first,
  input  slh_pkg::word_t    data_word,
  input  slh_pkg::count_t   byte_count,
  input  logic              last,
  output logic              done_push,
  output slh_pkg::hash_t    done_acc
);

  slh_pkg::hash_t acc_r, acc_nxt;
  slh_pkg::hash_t base;

  always_comb begin
    base = first ? seed : acc_r;
    // counts of four and above all take the full round
    if (byte_count[2]) begin
      acc_nxt = slh_pkg::full_round(base, data_word);
    end else begin
      acc_nxt = slh_pkg::tail_round(base, data_word, byte_count[1:0]);
    end
  end

  assign done_push = accept && last;
  assign done_acc  = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== sv/slh_back.sv =====
// ----------------------------------------------------------------------------
// slh_back: finalization pipeline
// Three-stage avalanche on queued accumulators, feeding the result queue.
// ----------------------------------------------------------------------------
module slh_back #(
  parameter int unsigned DEPTH = slh_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           src_empty,
  input  slh_pkg::hash_t src_data,
  output logic           src_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output slh_pkg::hash_t out_hash
);

  logic           v1_r, v2_r, v3_r;
  slh_pkg::hash_t d1_r, d2_r, d3_r;
  logic           advance;
  logic           res_full;

  // the whole pipeline holds only when its last stage cannot drain
  assign advance = !(v3_r && res_full);
  assign src_pop = advance && !src_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= !src_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_r <= slh_pkg::fin_step1(src_data);
      d2_r <= slh_pkg::fin_step2(d1_r);
      d3_r <= slh_pkg::fin_step3(d2_r);
    end
  end

  slh_fifo #(
    .DEPTH(DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (v3_r && advance),
    .wr_data (d3_r),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_hash),
    .empty   (out_empty)
  );

endmodule

// ===== sv/string_location_hash_top.sv =====
// ----------------------------------------------------------------------------
// string_location_hash_top: streaming 64-bit string hash
// Path: a last word's accumulator goes into the queue, then through the three
//   avalanche stages into the result queue, where out_empty goes low.
// Throughput: one word per cycle while in_full is low; the accumulator round is combinational.
// Reset: synchronous active-low rst_n clears accumulator, queues and stages.
// ----------------------------------------------------------------------------
module string_location_hash_top #(
  parameter int unsigned FIFO_DEPTH = slh_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  slh_pkg::hash_t  in_seed,
  input  logic            in_first,
  input  slh_pkg::word_t  in_data_word,
  input  slh_pkg::count_t in_byte_count,
  input  logic            in_last,
  output logic            out_empty,
  input  logic            out_pop,
  output slh_pkg::hash_t  out_hash
);

  logic           accept;
  logic           done_push;
  slh_pkg::hash_t done_acc;
  logic           mid_full;
  logic           mid_empty;
  logic           mid_pop;
  slh_pkg::hash_t mid_data;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  slh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .seed       (in_seed),
    .first      (in_first),
    .data_word  (in_data_word),
    .byte_count (in_byte_count),
    .last       (in_last),
    .done_push  (done_push),
    .done_acc   (done_acc)
  );

  // pre-final accumulators waiting for the avalanche
  slh_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (done_push),
    .wr_data (done_acc),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_data),
    .empty   (mid_empty)
  );

  slh_back #(
    .DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_empty (mid_empty),
    .src_data  (mid_data),
    .src_pop   (mid_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_hash  (out_hash)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for string_location_hash_top
// Streams hand-picked words and then random byte strings through the hash
// block. Both sides go idle at random. Every hash that comes out is compared
// with a hash typed into the table or a bit-exact software copy of the mixing rounds and the avalanche.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NUM_DIRECTED = 21;
  localparam int unsigned RANDOM_WORDS = 920;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    slh_pkg::hash_t  seed;
    logic            first;
    slh_pkg::word_t  word;
    slh_pkg::count_t count;
    logic            last;
    bit              known;   // hash typed into the table
    slh_pkg::hash_t  hash;
  } word_req_t;

  logic            clk;
  logic            rst_n;
  logic            in_push;
  logic            in_full;
  slh_pkg::hash_t  in_seed;
  logic            in_first;
  slh_pkg::word_t  in_data_word;
  slh_pkg::count_t in_byte_count;
  logic            in_last;
  logic            out_empty;
  logic            out_pop;
  slh_pkg::hash_t  out_hash;

  slh_pkg::hash_t hash_state;
  slh_pkg::hash_t pending_hashes[$];
  slh_pkg::hash_t want_hash;
  word_req_t      directed_rows[NUM_DIRECTED];
  int unsigned    words_sent;
  int unsigned    hashes_checked;
  int unsigned    mismatch_count;
  int unsigned    pop_wait;
  bit             steady;

  string_location_hash_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_seed       (in_seed),
    .in_first      (in_first),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_hash      (out_hash)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---- hash prediction ----

  function automatic slh_pkg::hash_t sign_byte(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  // temporary is truncated to 32 bits
  function automatic slh_pkg::hash_t mix_full_word(input slh_pkg::hash_t h,
                                                   input slh_pkg::word_t w);
    slh_pkg::hash_t a;
    slh_pkg::hash_t b;
    logic [31:0]    mixed;
    a     = h + slh_pkg::hash_t'(w[15:0]);
    mixed = a[31:0] ^ {5'b0, w[31:16], 11'b0};
    b     = (a << 16) ^ slh_pkg::hash_t'(mixed);
    return b + (b >> 11);
  endfunction

  function automatic slh_pkg::hash_t mix_tail(input slh_pkg::hash_t h,
                                              input slh_pkg::word_t w,
                                              input slh_pkg::count_t n);
    slh_pkg::hash_t a;
    a = h;
    case (n)
      3'd3: begin
        a = a + slh_pkg::hash_t'(w[15:0]);
        a = a ^ (a << 16);
        a = a ^ (sign_byte(w[23:16]) << 18);
        a = a + (a >> 11);
      end
      3'd2: begin
        a = a + slh_pkg::hash_t'(w[15:0]);
        a = a ^ (a << 11);
        a = a + (a >> 17);
      end
      3'd1: begin
        a = a + sign_byte(w[7:0]);
        a = a ^ (a << 10);
        a = a + (a >> 1);
      end
      default: begin
        a = h;
      end
    endcase
    return a;
  endfunction

  function automatic slh_pkg::hash_t avalanche(input slh_pkg::hash_t h);
    slh_pkg::hash_t a;
    a = h ^ (h << 3);
    a = a + (a >> 5);
    a = a ^ (a << 4);
    a = a + (a >> 17);
    a = a ^ (a << 25);
    a = a + (a >> 6);
    return a;
  endfunction

  task automatic absorb_word(input word_req_t req);
    if (req.first) hash_state = req.seed;
    if (req.count >= 3'd4) hash_state = mix_full_word(hash_state, req.word);
    else hash_state = mix_tail(hash_state, req.word, req.count);
    if (req.last) pending_hashes.push_back(req.known ? req.hash : avalanche(hash_state));
  endtask

  // ---- idling ----

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (steady) begin
      out_pop <= 1'b1;
    end else if (pop_wait != 0) begin
      pop_wait--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_wait = idle_length();
    end
  end

  // ---- stimulus ----

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_word(input word_req_t req);
    int unsigned gap;
    gap = steady ? 0 : idle_length();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_seed       <= req.seed;
    in_first      <= req.first;
    in_data_word  <= req.word;
    in_byte_count <= req.count;
    in_last       <= req.last;
    in_push       <= 1'b1;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    absorb_word(req);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic slh_pkg::hash_t pick_seed();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_string();
    int unsigned n_full;
    bit          drop_first;
    bit          drop_last;
    word_req_t   req;
    req.known = 1'b0;
    req.hash  = '0;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any field combination
      req.seed  = pick_seed();
      req.first = 1'($urandom_range(0, 1));
      req.word  = $urandom;
      req.count = slh_pkg::count_t'($urandom_range(0, 7));
      req.last  = 1'($urandom_range(0, 1));
      send_word(req);
    end else begin
      n_full     = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      drop_first = ($urandom_range(0, 19) == 0);
      drop_last  = ($urandom_range(0, 19) == 0);
      req.seed   = pick_seed();
      for (int unsigned i = 0; i <= n_full; i++) begin
        req.first = (i == 0) && !drop_first;
        req.word  = $urandom;
        if (i == n_full) begin
          req.count = slh_pkg::count_t'($urandom_range(0, 4));
          req.last  = !drop_last;
        end else begin
          req.count = ($urandom_range(0, 19) == 0) ?
                      slh_pkg::count_t'($urandom_range(5, 7)) : 3'd4;
          req.last  = 1'b0;
        end
        send_word(req);
        req.seed = pick_seed();
      end
    end
  endtask

  initial begin
    directed_rows = '{
      // after reset the accumulator is zero, so an empty last word hashes to zero
      '{64'h0, 1'b0, 32'h1234_5678, 3'd0, 1'b1, 1'b1, 64'h0},
      '{64'h0, 1'b1, 32'hffff_ffff, 3'd0, 1'b1, 1'b1, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 1'b1, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 1'b1, 32'hffff_ffff, 3'd4, 1'b0, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'h0000_0000, 3'd4, 1'b1, 1'b0, 64'h0},
      // counts above four run a full round
      '{64'h0123_4567_89ab_cdef, 1'b1, 32'ha5a5_5a5a, 3'd5, 1'b0, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'h8001_7fff, 3'd6, 1'b0, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'hffff_ffff, 3'd7, 1'b1, 1'b0, 64'h0},
      // three byte tails, odd byte negative and positive
      '{64'h0, 1'b1, 32'h0080_1234, 3'd3, 1'b1, 1'b0, 64'h0},
      '{64'h0, 1'b1, 32'hff7f_fedc, 3'd3, 1'b1, 1'b0, 64'h0},
      '{64'h1, 1'b1, 32'hdead_beef, 3'd2, 1'b1, 1'b0, 64'h0},
      '{64'h0, 1'b1, 32'hffff_ff80, 3'd1, 1'b1, 1'b0, 64'h0},
      '{64'h0, 1'b1, 32'h0000_007f, 3'd1, 1'b1, 1'b0, 64'h0},
      // short word in mid string keeps going
      '{64'h8000_0000_0000_0000, 1'b1, 32'hcafe_f00d, 3'd2, 1'b0, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'h1357_9bdf, 3'd4, 1'b0, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'hffff_ff81, 3'd1, 1'b1, 1'b0, 64'h0},
      // no first after a finished string
      '{64'h0, 1'b0, 32'h0bad_f00d, 3'd4, 1'b1, 1'b0, 64'h0},
      // restart in mid string
      '{64'h5555_5555_5555_5555, 1'b1, 32'h1111_1111, 3'd4, 1'b0, 1'b0, 64'h0},
      '{64'haaaa_aaaa_aaaa_aaaa, 1'b1, 32'h2222_2222, 3'd4, 1'b0, 1'b0, 64'h0},
      '{64'hffff_ffff_ffff_ffff, 1'b1, 32'h0000_0000, 3'd4, 1'b1, 1'b0, 64'h0},
      '{64'h0, 1'b0, 32'hffff_ffff, 3'd3, 1'b1, 1'b0, 64'h0}
    };

    hash_state     = '0;
    words_sent     = 0;
    hashes_checked = 0;
    mismatch_count = 0;
    pop_wait       = 0;
    steady         = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_seed        = '0;
    in_first       = 1'b0;
    in_data_word   = '0;
    in_byte_count  = '0;
    in_last        = 1'b0;
    out_pop        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int unsigned i = 0; i < NUM_DIRECTED; i++) send_word(directed_rows[i]);

    while (words_sent < NUM_DIRECTED + RANDOM_WORDS) begin
      // a stretch with no idling on either side
      steady = (words_sent >= 300) && (words_sent < 420);
      send_string();
    end
    steady = 1'b0;
    in_push <= 1'b0;

    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, compared %0d hashes, %0d mismatches", words_sent,
             hashes_checked, mismatch_count);
    $display("covered empty strings, every tail length, counts above four and broken framing");
    if (mismatch_count == 0) begin
      $display("string_location_hash_top verification clean");
    end else begin
      $display("string_location_hash_top verification failed");
    end
    $finish;
  end

  // ---- result checking ----

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash transfer, expected none, got %h", $time, out_hash);
        mismatch_count++;
      end else begin
        want_hash = pending_hashes.pop_front();
        hashes_checked++;
        if (out_hash !== want_hash) begin
          $display("%0t: hash mismatch, expected %h, got %h", $time, want_hash, out_hash);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d hashes outstanding", $time, pending_hashes.size());
    $display("string_location_hash_top verification failed");
    $finish;
  end

endmodule
